// File: sv/etsc_pkg.sv
`default_nettype none
package etsc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int ITER_WIDTH  = 16;
  localparam int FRAC_BITS   = COORD_WIDTH - 4;
  localparam int Z_W         = 64;
  localparam int PROD_W      = 2 * Z_W;
  localparam int COUNT_W     = 24;
  localparam int LQ8_W       = 14;
  localparam int ESC_SHIFT   = 20 + FRAC_BITS;

  typedef enum logic [1:0] {
    CFG_JULIA_MODE = 2'd0,
    CFG_JULIA_C_RE = 2'd1,
    CFG_JULIA_C_IM = 2'd2,
    CFG_MAX_ITER   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_XX = 2'd0,
    OP_YY = 2'd1,
    OP_XY = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_re;
    logic signed [COORD_WIDTH-1:0] point_im;
  } point_t;

  typedef struct packed {
    logic                  escaped;
    logic [COUNT_W-1:0]    smooth_count;
    logic [ITER_WIDTH-1:0] iter_count;
  } result_t;

  typedef struct packed {
    logic                  valid;
    mul_op_t               tag;
    logic                  sh_one;
    logic signed [Z_W-1:0] a;
    logic signed [Z_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  valid;
    mul_op_t               tag;
    logic signed [Z_W-1:0] value;
  } mul_rsp_t;

  typedef struct packed {
    logic              valid;
    mul_op_t           tag;
    logic              sh_one;
    logic              neg;
    logic [Z_W-1:0]    ua;
    logic [Z_W-1:0]    ub;
    logic [PROD_W-1:0] acc;
    logic [Z_W-1:0]    pp;
  } cell_bus_t;

  localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  function automatic logic signed [Z_W-1:0] sat_add(input logic signed [Z_W-1:0] a,
                                                     input logic signed [Z_W-1:0] b);
    logic signed [Z_W:0] s;
    s = {a[Z_W-1], a} + {b[Z_W-1], b};
    if (s[Z_W] != s[Z_W-1]) return s[Z_W] ? Z_MIN : Z_MAX;
    return s[Z_W-1:0];
  endfunction

  function automatic logic signed [Z_W-1:0] sat_sub(input logic signed [Z_W-1:0] a,
                                                     input logic signed [Z_W-1:0] b);
    logic signed [Z_W:0] s;
    s = {a[Z_W-1], a} - {b[Z_W-1], b};
    if (s[Z_W] != s[Z_W-1]) return s[Z_W] ? Z_MIN : Z_MAX;
    return s[Z_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/etsc_mul_cell.sv
`default_nettype none
module etsc_mul_cell #(
  parameter int A_DIG    = 0,
  parameter int B_DIG    = 0,
  parameter int PREV_OFF = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  etsc_pkg::cell_bus_t  left,
  output etsc_pkg::cell_bus_t  right
);
  import etsc_pkg::*;

  always_ff @(posedge clk) begin
    right.tag    <= left.tag;
    right.sh_one <= left.sh_one;
    right.neg    <= left.neg;
    right.ua     <= left.ua;
    right.ub     <= left.ub;
    right.acc    <= left.acc + (PROD_W'(left.pp) << PREV_OFF);
    right.pp     <= Z_W'(left.ua[A_DIG*32 +: 32]) * Z_W'(left.ub[B_DIG*32 +: 32]);
    if (rst) begin
      right.valid <= 1'b0;
    end else begin
      right.valid <= left.valid;
    end
  end

endmodule
`default_nettype wire

// File: sv/etsc_mul.sv
`default_nettype none
module etsc_mul (
  input  logic               clk,
  input  logic               rst,
  input  etsc_pkg::mul_req_t req,
  output etsc_pkg::mul_rsp_t rsp
);
  import etsc_pkg::*;

  localparam logic [PROD_W-1:0] MASK_F  = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
  localparam logic [PROD_W-1:0] MASK_F1 = (PROD_W'(1) << (FRAC_BITS - 1)) - PROD_W'(1);

  cell_bus_t bus [5];

  always_ff @(posedge clk) begin
    bus[0].tag    <= req.tag;
    bus[0].sh_one <= req.sh_one;
    bus[0].neg    <= req.a[Z_W-1] ^ req.b[Z_W-1];
    bus[0].ua     <= req.a[Z_W-1] ? Z_W'(-req.a) : Z_W'(req.a);
    bus[0].ub     <= req.b[Z_W-1] ? Z_W'(-req.b) : Z_W'(req.b);
    bus[0].acc    <= '0;
    bus[0].pp     <= '0;
    if (rst) begin
      bus[0].valid <= 1'b0;
    end else begin
      bus[0].valid <= req.valid;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_cell
    localparam int AD = j >> 1;
    localparam int BD = j & 1;
    localparam int PO = (j == 0) ? 0 : 32 * (((j - 1) >> 1) + ((j - 1) & 1));
    etsc_mul_cell #(.A_DIG(AD), .B_DIG(BD), .PREV_OFF(PO)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .left  (bus[j]),
      .right (bus[j+1])
    );
  end

  logic              t_valid;
  mul_op_t           t_tag;
  logic              t_sh_one;
  logic              t_neg;
  logic [PROD_W-1:0] t_prod;

  always_ff @(posedge clk) begin
    t_tag    <= bus[4].tag;
    t_sh_one <= bus[4].sh_one;
    t_neg    <= bus[4].neg;
    t_prod   <= bus[4].acc + (PROD_W'(bus[4].pp) << 64);
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= bus[4].valid;
    end
  end

  logic [PROD_W-1:0] shifted;
  logic              s_valid;
  mul_op_t           s_tag;
  logic              s_neg;
  logic              s_big;
  logic              s_rem;
  logic [Z_W-2:0]    s_q;

  assign shifted = t_sh_one ? (t_prod >> (FRAC_BITS - 1)) : (t_prod >> FRAC_BITS);

  always_ff @(posedge clk) begin
    s_tag <= t_tag;
    s_neg <= t_neg;
    s_big <= |shifted[PROD_W-1:Z_W-1];
    s_q   <= shifted[Z_W-2:0];
    s_rem <= |(t_prod & (t_sh_one ? MASK_F1 : MASK_F));
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp.tag <= s_tag;
    if (!s_neg) begin
      rsp.value <= s_big ? Z_MAX : {1'b0, s_q};
    end else if (s_big || (&s_q && s_rem)) begin
      rsp.value <= Z_MIN;
    end else begin
      rsp.value <= ~{1'b0, s_q} + Z_W'(!s_rem);
    end
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= s_valid;
    end
  end

endmodule
`default_nettype wire

// File: sv/etsc_log.sv
`default_nettype none
module etsc_log #(
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [etsc_pkg::Z_W-1:0]   value,
  output logic                       done,
  output logic [etsc_pkg::LQ8_W-1:0] log_q8
);
  import etsc_pkg::*;

  localparam int IDX_W = (LOG_TABLE_DEPTH > 1) ? $clog2(LOG_TABLE_DEPTH) : 1;

  function automatic logic [7:0] table_frac(input int unsigned idx);
    logic [63:0] x;
    logic [7:0]  r;
    x = (64'd1 << 30) + ((64'(idx) << 30) / 64'(LOG_TABLE_DEPTH));
    r = '0;
    for (int i = 0; i < 8; i++) begin
      x = (x * x) >> 30;
      r = {r[6:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

  logic [7:0] tbl [LOG_TABLE_DEPTH];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_tbl
    localparam logic [7:0] ENTRY = table_frac(gi);
    assign tbl[gi] = ENTRY;
  end

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_IDX, L_OUT} lstate_t;

  lstate_t          state;
  logic [Z_W-2:0]   n;
  logic [5:0]       p;
  logic [IDX_W-1:0] idx;
  logic [31+IDX_W:0] scaled;

  assign scaled = {{IDX_W{1'b0}}, n[61:30]} * (32 + IDX_W)'(LOG_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    case (state)
      L_IDLE: begin
        if (start) begin
          n     <= value[Z_W-2:0];
          p     <= 6'd62;
          state <= L_NORM;
        end
      end
      L_NORM: begin
        if (n[Z_W-2]) begin
          state <= L_IDX;
        end else begin
          n <= n << 1;
          p <= p - 6'd1;
        end
      end
      L_IDX: begin
        idx   <= scaled[31+IDX_W:32];
        state <= L_OUT;
      end
      L_OUT: begin
        log_q8 <= {p, 8'h00} + LQ8_W'(tbl[idx]);
        done   <= 1'b1;
        state  <= L_IDLE;
      end
      default: state <= L_IDLE;
    endcase
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/escape_time_fractal_smooth_count_top.sv
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------
// point    | start, busy                | point (point_re, point_im)
// result   | result_valid (strobe)      | result (escaped, smooth_count,
//          |                            |   iter_count)
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One point at a time. Each iteration makes two passes through the
// eight-stage multiplier chain (three products, then the two squares of the new z).
// A point that reaches max_iter answers once max_iter iterations have run.
// An escaped point adds two log passes; the log normalizer shifts
// one bit per cycle. A max_iter of zero answers in the cycle after start.
// rst is synchronous; registers come up as Mandelbrot mode, max_iter 256.
// The result is a one-cycle strobe; busy drops at the same edge.
`default_nettype none
module escape_time_fractal_smooth_count_top #(
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  etsc_pkg::point_t                 point,
  output logic                             result_valid,
  output etsc_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  etsc_pkg::cfg_idx_t               cfg_index,
  input  logic [etsc_pkg::COORD_WIDTH-1:0] cfg_data
);
  import etsc_pkg::*;

  localparam logic signed [Z_W-1:0] ESC_THR = Z_W'(1) << ESC_SHIFT;
  localparam int VW = ITER_WIDTH + 10;
  localparam logic signed [VW-1:0] WRAP  = VW'(262144);
  localparam logic signed [VW-1:0] WRAP2 = VW'(524288);
  localparam logic signed [VW-1:0] LL_BIAS = VW'(2304);
  localparam logic signed [VW-1:0] CNT_MAX = VW'(24'hFFFFFF);
  localparam logic [LQ8_W-1:0] FRAC_Q8 = LQ8_W'(FRAC_BITS * 256);

  logic                          julia_mode;
  logic signed [COORD_WIDTH-1:0] julia_c_re;
  logic signed [COORD_WIDTH-1:0] julia_c_im;
  logic [ITER_WIDTH-1:0]         max_iter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      julia_mode <= 1'b0;
      julia_c_re <= '0;
      julia_c_im <= '0;
      max_iter   <= ITER_WIDTH'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_JULIA_MODE: julia_mode <= cfg_data[0];
        CFG_JULIA_C_RE: julia_c_re <= cfg_data;
        CFG_JULIA_C_IM: julia_c_im <= cfg_data;
        CFG_MAX_ITER:   max_iter   <= cfg_data[ITER_WIDTH-1:0];
        default:        max_iter   <= max_iter;
      endcase
    end
  end

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE_A, S_WAIT_A, S_UPD1, S_UPD2, S_ISSUE_B, S_WAIT_B, S_CHECK,
    S_LOG_A, S_LOG_A_W, S_LOG_B, S_LOG_B_W, S_FIN1, S_FIN2
  } state_t;

  state_t                state;
  mul_op_t               op_cnt;
  logic signed [Z_W-1:0] zx, zy, cx, cy, dx;
  logic signed [Z_W-1:0] pxx, pyy, pxy, r2;
  logic [ITER_WIDTH-1:0] k, lim;
  logic [LQ8_W-1:0]      la, lb;
  logic signed [VW-1:0]  v;

  mul_req_t              mreq;
  mul_rsp_t              mrsp;
  logic                  log_start, log_done;
  logic [Z_W-1:0]        log_value;
  logic [LQ8_W-1:0]      log_q8;
  logic signed [Z_W-1:0] r2_sum;
  logic signed [Z_W-1:0] pre, pim, jre, jim;
  logic signed [VW-1:0]  v_wrap;

  assign pre = {{(Z_W-COORD_WIDTH){point.point_re[COORD_WIDTH-1]}}, point.point_re};
  assign pim = {{(Z_W-COORD_WIDTH){point.point_im[COORD_WIDTH-1]}}, point.point_im};
  assign jre = {{(Z_W-COORD_WIDTH){julia_c_re[COORD_WIDTH-1]}}, julia_c_re};
  assign jim = {{(Z_W-COORD_WIDTH){julia_c_im[COORD_WIDTH-1]}}, julia_c_im};

  always_comb begin
    mreq.valid  = (state == S_ISSUE_A) || (state == S_ISSUE_B);
    mreq.tag    = op_cnt;
    mreq.sh_one = (op_cnt == OP_XY);
    mreq.a      = (op_cnt == OP_YY) ? zy : zx;
    mreq.b      = (op_cnt == OP_XX) ? zx : zy;
  end

  etsc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign log_start = (state == S_LOG_A) || (state == S_LOG_B);
  assign log_value = (state == S_LOG_A) ? Z_W'(r2) : Z_W'(la - FRAC_Q8);

  etsc_log #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .value  (log_value),
    .done   (log_done),
    .log_q8 (log_q8)
  );

  assign r2_sum = sat_add(pxx, pyy);

  always_comb begin
    if (v < 0) begin
      v_wrap = v + WRAP2;
    end else if (v < WRAP) begin
      v_wrap = v + WRAP;
    end else begin
      v_wrap = v;
    end
  end

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (mrsp.valid) begin
      case (mrsp.tag)
        OP_XX:   pxx <= mrsp.value;
        OP_YY:   pyy <= mrsp.value;
        default: pxy <= mrsp.value;
      endcase
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          op_cnt <= OP_XX;
          k      <= '0;
          lim    <= max_iter;
          if (julia_mode) begin
            zx <= pre;
            zy <= pim;
            cx <= jre;
            cy <= jim;
          end else begin
            zx <= '0;
            zy <= '0;
            cx <= pre;
            cy <= pim;
          end
          if (max_iter == '0) begin
            result_valid        <= 1'b1;
            result.escaped      <= 1'b0;
            result.smooth_count <= '0;
            result.iter_count   <= '0;
          end else begin
            busy  <= 1'b1;
            state <= S_ISSUE_A;
          end
        end
      end
      S_ISSUE_A: begin
        case (op_cnt)
          OP_XX:   op_cnt <= OP_YY;
          OP_YY:   op_cnt <= OP_XY;
          default: begin
            op_cnt <= OP_XX;
            state  <= S_WAIT_A;
          end
        endcase
      end
      S_WAIT_A: begin
        if (mrsp.valid && mrsp.tag == OP_XY) state <= S_UPD1;
      end
      S_UPD1: begin
        dx    <= sat_sub(pxx, pyy);
        zy    <= sat_add(pxy, cy);
        state <= S_UPD2;
      end
      S_UPD2: begin
        zx    <= sat_add(dx, cx);
        state <= S_ISSUE_B;
      end
      S_ISSUE_B: begin
        case (op_cnt)
          OP_XX:   op_cnt <= OP_YY;
          default: begin
            op_cnt <= OP_XX;
            state  <= S_WAIT_B;
          end
        endcase
      end
      S_WAIT_B: begin
        if (mrsp.valid && mrsp.tag == OP_YY) state <= S_CHECK;
      end
      S_CHECK: begin
        r2 <= r2_sum;
        if (r2_sum > ESC_THR) begin
          state <= S_LOG_A;
        end else if (({1'b0, k} + 1'b1) == {1'b0, lim}) begin
          result_valid        <= 1'b1;
          result.escaped      <= 1'b0;
          result.smooth_count <= '0;
          result.iter_count   <= lim;
          busy                <= 1'b0;
          state               <= S_IDLE;
        end else begin
          k     <= k + 1'b1;
          state <= S_ISSUE_A;
        end
      end
      S_LOG_A:   state <= S_LOG_A_W;
      S_LOG_A_W: begin
        if (log_done) begin
          la    <= log_q8;
          state <= S_LOG_B;
        end
      end
      S_LOG_B:   state <= S_LOG_B_W;
      S_LOG_B_W: begin
        if (log_done) begin
          lb    <= log_q8;
          state <= S_FIN1;
        end
      end
      S_FIN1: begin
        v     <= $signed({2'b00, k, 8'h00}) - $signed(VW'(lb)) + LL_BIAS;
        state <= S_FIN2;
      end
      S_FIN2: begin
        result_valid        <= 1'b1;
        result.escaped      <= 1'b1;
        result.smooth_count <= (v_wrap > CNT_MAX) ? {COUNT_W{1'b1}} : v_wrap[COUNT_W-1:0];
        result.iter_count   <= k + 1'b1;
        busy                <= 1'b0;
        state               <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
      op_cnt       <= OP_XX;
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && max_iter != '0 |=> busy)
    else $error("accepted transaction did not raise busy");
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.escaped |-> result.smooth_count == '0)
    else $error("non-escaped point with nonzero smooth count");
  a_count_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.escaped |-> result.smooth_count >= 24'd262144)
    else $error("smooth count below wrap floor");
  a_escape_iter: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.escaped |-> result.iter_count != '0)
    else $error("escaped point with zero iteration count");
`endif

endmodule
`default_nettype wire

// File: dv/tb_escape_time_fractal_smooth_count_top.sv
`timescale 1ns / 1ps
module tb_escape_time_fractal_smooth_count_top;
  import etsc_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam longint L_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint L_MIN = 64'sh8000_0000_0000_0000;

  class fractal_scoreboard;
    result_t expq[$];
    int errors;
    bit jmode;
    logic signed [31:0] jre, jim;
    logic [15:0] miter;

    function new();
      errors = 0;
      jmode = 0;
      jre = 0;
      jim = 0;
      miter = 16'd256;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        CFG_JULIA_MODE: jmode = d[0];
        CFG_JULIA_C_RE: jre = d;
        CFG_JULIA_C_IM: jim = d;
        CFG_MAX_ITER:   miter = d[15:0];
        default: ;
      endcase
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? L_MIN : L_MAX;
      return s;
    endfunction

    function longint ssub(longint a, longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? L_MIN : L_MAX;
      return s;
    endfunction

    // full product, floor shift, clamp to 64 bits
    function longint mul_sh(longint a, longint b, int sh);
      logic signed [127:0] p, q;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      q = p >>> sh;
      if (q[127:63] != {65{q[127]}}) return q[127] ? L_MIN : L_MAX;
      return q[63:0];
    endfunction

    function longint frac_lut(longint idx);
      bit [63:0] x;
      longint r;
      x = (64'd1 << 30) + ((idx << 30) / 64);
      r = 0;
      for (int i = 0; i < 8; i++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd2 << 30)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      return r;
    endfunction

    function longint log2_q8(longint v);
      int pos;
      bit [63:0] n, fr, idx;
      pos = 0;
      while (pos < 62 && (v >> (pos + 1)) != 0) pos++;
      n = v << (62 - pos);
      fr = n - (64'd1 << 62);
      idx = ((fr >> 30) * 64) >> 32;
      if (idx >= 64) idx = 63;
      return longint'(pos) * 256 + frac_lut(idx);
    endfunction

    function result_t predict(point_t p);
      longint zx, zy, cx, cy, r2, xx, yy, xy2, l1, ll, v;
      int k;
      bit esc;
      result_t r;
      esc = 0;
      r2 = 0;
      if (jmode) begin
        zx = p.point_re;
        zy = p.point_im;
        cx = jre;
        cy = jim;
      end else begin
        zx = 0;
        zy = 0;
        cx = p.point_re;
        cy = p.point_im;
      end
      for (k = 0; k < miter; k++) begin
        xx = mul_sh(zx, zx, FRAC_BITS);
        yy = mul_sh(zy, zy, FRAC_BITS);
        xy2 = mul_sh(zx, zy, FRAC_BITS - 1);
        zx = sadd(ssub(xx, yy), cx);
        zy = sadd(xy2, cy);
        r2 = sadd(mul_sh(zx, zx, FRAC_BITS), mul_sh(zy, zy, FRAC_BITS));
        if (r2 > (64'sd1 <<< ESC_SHIFT)) begin
          esc = 1;
          break;
        end
      end
      if (esc) begin
        l1 = log2_q8(r2) - FRAC_BITS * 256;
        ll = log2_q8(l1) - 2304;
        v = longint'(k) * 256 - ll;
        while (v < 262144) v += 262144;
        if (v > 64'sd16777215) v = 16777215;
        r.escaped = 1'b1;
        r.smooth_count = v[23:0];
        r.iter_count = 16'(k + 1);
      end else begin
        r.escaped = 1'b0;
        r.smooth_count = '0;
        r.iter_count = miter;
      end
      return r;
    endfunction

    function void note(point_t p);
      expq.push_back(predict(p));
    endfunction

    function void check(result_t r);
      result_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result %h", $time, r);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (r.escaped !== e.escaped) begin
        $display("%0t: escaped exp %0d act %0d", $time, e.escaped, r.escaped);
        errors++;
      end
      if (r.smooth_count !== e.smooth_count) begin
        $display("%0t: smooth_count exp %0d act %0d", $time, e.smooth_count, r.smooth_count);
        errors++;
      end
      if (r.iter_count !== e.iter_count) begin
        $display("%0t: iter_count exp %0d act %0d", $time, e.iter_count, r.iter_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  point_t pt = '0;
  logic result_valid;
  result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_JULIA_MODE;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  fractal_scoreboard sb = new();
  bit quiet = 0;
  int idle_cnt = 0;

  escape_time_fractal_smooth_count_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(pt),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_point(logic signed [31:0] re, logic signed [31:0] im);
    point_t p;
    p.point_re = re;
    p.point_im = im;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    pt <= p;
    do @(posedge clk); while (busy);
    sb.note(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic set_cfg(bit mode, logic [31:0] cre, logic [31:0] cim, logic [15:0] mi);
    logic [31:0] d;
    drain();
    d = $urandom();
    d[0] = mode;
    write_reg(CFG_JULIA_MODE, d);
    write_reg(CFG_JULIA_C_RE, cre);
    write_reg(CFG_JULIA_C_IM, cim);
    d = $urandom();
    d[15:0] = mi;
    write_reg(CFG_MAX_ITER, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(bit wide);
    if (wide || $urandom_range(0, 99) < 30) return $urandom();
    return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
  endfunction

  initial begin
    logic [31:0] cre, cim;
    logic [15:0] mi;
    real ang;
    int n;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings
    send_point(0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh8000_0000, 0);
    send_point(0, 32'sh7FFF_FFFF);
    send_point(-32'sh2000_0000, 0);
    send_point(32'sh0400_0000, 0);
    send_point(32'sh1000_0000, 0);
    send_point(32'sh0000_0001, 32'shFFFF_FFFF);
    set_cfg(0, 0, 0, 16'd0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(0, 0);
    set_cfg(0, 0, 0, 16'd1);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh1000_0000, 32'sh1000_0000);
    set_cfg(0, 0, 0, 16'hFFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh0000_0000);
    send_point(32'shC000_0000, 32'sh5000_0000);
    set_cfg(1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    set_cfg(1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd64);
    send_point(0, 0);
    send_point(32'sh0800_0000, 32'shF800_0000);

    for (int ph = 0; ph < 36; ph++) begin
      r = $urandom_range(0, 3);
      if (r < 2) begin
        ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        cre = $rtoi(0.7885 * $cos(ang) * 268435456.0);
        cim = $rtoi(0.7885 * $sin(ang) * 268435456.0);
      end else if (r == 2) begin
        cre = $urandom();
        cim = $urandom();
      end else begin
        cre = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
        cim = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      end
      if (ph % 8 == 7) begin
        mi = $urandom_range(100, 300);
        n = 12;
      end else begin
        mi = $urandom_range(1, 24);
        n = 52;
      end
      quiet = (ph >= 12 && ph < 18);
      set_cfg($urandom_range(0, 1), cre, cim, mi);
      for (int i = 0; i < n; i++) send_point(rand_coord(0), rand_coord(0));
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
